// ===== src/ipacl_pkg.sv =====
// shared types, constants and helpers for the ipv4 prefix access list
package ipacl_pkg;

	localparam int RULE_DEPTH  = 64;
	localparam int ZONE_COUNT  = 8;
	localparam int IDX_W       = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(RULE_DEPTH + 1);
	localparam int ADDR_W      = 32;
	localparam int ZONE_W      = 3;
	localparam int PLEN_W      = 6;
	localparam int HITS_W      = 8;
	localparam int CMD_W       = 2;
	localparam logic [ADDR_W-1:0] FULL_MASK = 32'hFFFF_FFFF;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_LOOKUP = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] mask;
		logic              allow;
		logic [ZONE_W-1:0] zone;
	} rule_t;

	localparam int RULE_W = $bits(rule_t);

	typedef struct packed {
		logic start;
		logic eval;
	} match_ctrl_t;

	typedef struct packed {
		logic found;
		logic allow;
	} match_res_t;

	// prefix length to netmask, lengths past 32 saturate
	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
		logic [ADDR_W-1:0] m;
		if (plen >= PLEN_W'(32)) begin
			m = FULL_MASK;
		end else begin
			m = ~(FULL_MASK >> plen[4:0]);
		end
		return m;
	endfunction

endpackage

// ===== src/ipacl_if.sv =====
// request and response channel interfaces
interface ipacl_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [2:0]  zone;
	logic [31:0] address;
	logic [5:0]  prefix_len;
	logic        allow;
	logic [7:0]  zone_hits;

	modport source (output valid, command, zone, address, prefix_len, allow, zone_hits,
		input ready);
	modport sink (input valid, command, zone, address, prefix_len, allow, zone_hits,
		output ready);
endinterface

interface ipacl_rsp_if;
	logic valid;
	logic ready;
	logic permitted;
	logic matched;
	logic status;

	modport source (output valid, permitted, matched, status, input ready);
	modport sink (input valid, permitted, matched, status, output ready);
endinterface

// ===== src/ipacl_ram.sv =====
// generic single write, single read ram with registered read data
module ipacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                           wr_data,
	input  logic                                       rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                           rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

// ===== src/ipacl_match.sv =====
// rule compare and best match tracking over a scan
module ipacl_match (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  ipacl_pkg::match_ctrl_t                     ctrl,
	input  ipacl_pkg::rule_t                           rule,
	input  logic [ipacl_pkg::ADDR_W-1:0]               peer,
	input  logic [ipacl_pkg::HITS_W-1:0]               hits,
	output ipacl_pkg::match_res_t                      res
);
	import ipacl_pkg::*;

	logic              found_q;
	logic              allow_q;
	logic [ZONE_W-1:0] zone_q;
	logic              zone_ok;
	logic              addr_eq;
	logic              better;
	logic              take;

	always_comb begin
		zone_ok = (int'(rule.zone) < ZONE_COUNT) && hits[rule.zone];
		addr_eq = ((peer ^ rule.addr) & rule.mask) == '0;
		// lower zone wins, equal zone keeps the earlier rule
		better  = !found_q || (rule.zone < zone_q);
		take    = ctrl.eval && zone_ok && addr_eq && better;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctrl.start) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			allow_q <= rule.allow;
			zone_q  <= rule.zone;
		end
	end

	assign res.found = found_q;
	assign res.allow = found_q & allow_q;
endmodule

// ===== src/ipv4_prefix_acl_first_match.sv =====
// top level: first-match ipv4 access list with a ram rule table
// Rules sit in one ram in load order; clear resets the fill count and add writes the
// next free entry (status 1 when the table is full). A clear or add, or a lookup with
// filtering off, goes straight from acceptance to the done state. With filtering on, a
// lookup reads the ram one rule per cycle through its single read port and then enters
// the done state. The result is loaded into the output register once that is free, and
// the next item is taken in the idle state that follows. The pick is the matching rule
// of the lowest listed zone, earliest in load order within that zone; no match denies,
// and with filter_enable at 0 every lookup is permitted. One item is in work at a time;
// a result waits in the output register while the next item is taken in.
module ipv4_prefix_acl_first_match (
	input  logic              clk,
	input  logic              arst_n,
	ipacl_req_if.sink         req,
	ipacl_rsp_if.source       rsp,
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data
);
	import ipacl_pkg::*;

	state_t            state_q, state_d;
	logic              enable_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rd_cnt_q;
	logic              eval_s1;
	logic [ADDR_W-1:0] peer_q;
	logic [HITS_W-1:0] hits_q;
	logic              scan_q;
	logic              res_perm_q;
	logic              res_stat_q;
	logic              out_valid_q;
	logic              out_perm_q;
	logic              out_match_q;
	logic              out_stat_q;

	logic              accept;
	logic              is_clear, is_add, is_lookup;
	logic              full;
	logic              wr_en;
	logic              rd_en;
	logic              scan_end;
	logic              out_free;
	logic              out_load;
	rule_t             wr_rule;
	rule_t             rd_rule;
	match_ctrl_t       mctrl;
	match_res_t        mres;

	always_comb begin
		accept    = req.valid && (state_q == ST_IDLE);
		is_clear  = req.command == CMD_CLEAR;
		is_add    = req.command == CMD_ADD;
		is_lookup = req.command == CMD_LOOKUP;
		full      = count_q == CNT_W'(RULE_DEPTH);
		wr_en     = accept && is_add && !full;
		rd_en     = (state_q == ST_SCAN) && (rd_cnt_q < count_q);
		scan_end  = (state_q == ST_SCAN) && !rd_en && !eval_s1;
		out_free  = !out_valid_q || rsp.ready;
		out_load  = (state_q == ST_DONE) && out_free;
		wr_rule.addr  = req.address;
		wr_rule.mask  = prefix_mask(req.prefix_len);
		wr_rule.allow = req.allow;
		wr_rule.zone  = req.zone;
		mctrl.start = accept;
		mctrl.eval  = eval_s1;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (is_lookup && enable_q) ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req.ready     = state_q == ST_IDLE;
		rsp.valid     = out_valid_q;
		rsp.permitted = out_perm_q;
		rsp.matched   = out_match_q;
		rsp.status    = out_stat_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			enable_q    <= 1'b1;
			count_q     <= '0;
			rd_cnt_q    <= '0;
			eval_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				enable_q <= cfg_wr_data;
			end
			if (accept && is_clear) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (accept) begin
				rd_cnt_q <= '0;
			end else if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
			eval_s1 <= rd_en;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			peer_q     <= req.address;
			hits_q     <= req.zone_hits;
			scan_q     <= is_lookup && enable_q;
			res_perm_q <= is_lookup && !enable_q;
			res_stat_q <= is_add && full;
		end
		if (out_load) begin
			out_perm_q  <= scan_q ? mres.allow : res_perm_q;
			out_match_q <= scan_q && mres.found;
			out_stat_q  <= res_stat_q;
		end
	end

	ipacl_ram #(
		.WIDTH (RULE_W),
		.DEPTH (RULE_DEPTH)
	) u_rules (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (wr_rule),
		.rd_en   (rd_en),
		.rd_addr (rd_cnt_q[IDX_W-1:0]),
		.rd_data (rd_rule)
	);

	ipacl_match u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mctrl),
		.rule   (rd_rule),
		.peer   (peer_q),
		.hits   (hits_q),
		.res    (mres)
	);
endmodule

// ===== verif/ipv4_prefix_acl_first_match_tb.sv =====
// testbench for the first-match ipv4 prefix access list
module ipv4_prefix_acl_first_match_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ipacl_pkg::*;

	localparam logic [CMD_W-1:0] CMD_RSVD = 2'd3;
	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_ITEMS = 560;
	localparam int CALM_ITEMS = 40;

	typedef struct {
		logic [CMD_W-1:0]  command;
		logic [ZONE_W-1:0] zone;
		logic [ADDR_W-1:0] address;
		logic [PLEN_W-1:0] prefix_len;
		logic              allow;
		logic [HITS_W-1:0] zone_hits;
	} acl_item_t;

	typedef struct packed {
		logic permitted;
		logic matched;
		logic status;
	} acl_verdict_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;

	ipacl_req_if req_ch();
	ipacl_rsp_if rsp_ch();

	ipv4_prefix_acl_first_match u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// shadow copy of the rule table and filter switch
	logic [ADDR_W-1:0] shadow_addr [RULE_DEPTH];
	logic [ADDR_W-1:0] shadow_mask [RULE_DEPTH];
	logic              shadow_allow [RULE_DEPTH];
	logic [ZONE_W-1:0] shadow_zone [RULE_DEPTH];
	int unsigned       shadow_count;
	logic              filter_on;

	acl_verdict_t verdict_q[$];
	int unsigned  mismatches;
	int unsigned  items_sent;
	int unsigned  cycles;
	int unsigned  hold_left;
	bit           calm;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// prefix length to netmask, lengths past 32 count as 32
	function automatic logic [ADDR_W-1:0] netmask_of(logic [PLEN_W-1:0] plen);
		int unsigned p;
		p = (plen > PLEN_W'(32)) ? 32 : int'(plen);
		if (p == 0)
			return '0;
		return ADDR_W'(64'hFFFF_FFFF << (32 - p));
	endfunction

	// works out the verdict of one item and updates the shadow table
	function automatic acl_verdict_t acl_verdict(acl_item_t it);
		acl_verdict_t v;
		bit done;
		v = '0;
		done = 1'b0;
		case (it.command)
			CMD_CLEAR: shadow_count = 0;
			CMD_ADD: begin
				if (shadow_count >= RULE_DEPTH) begin
					v.status = 1'b1;
				end else begin
					shadow_addr[shadow_count] = it.address;
					shadow_mask[shadow_count] = netmask_of(it.prefix_len);
					shadow_allow[shadow_count] = it.allow;
					shadow_zone[shadow_count] = it.zone;
					shadow_count++;
				end
			end
			CMD_LOOKUP: begin
				if (!filter_on) begin
					v.permitted = 1'b1;
				end else begin
					for (int z = 0; z < ZONE_COUNT; z++) begin
						if (!done && it.zone_hits[z]) begin
							for (int i = 0; i < shadow_count; i++) begin
								if (!done && shadow_zone[i] == z &&
									(it.address & shadow_mask[i]) ==
									(shadow_addr[i] & shadow_mask[i])) begin
									v.matched = 1'b1;
									v.permitted = shadow_allow[i];
									done = 1'b1;
								end
							end
						end
					end
				end
			end
			default: ;
		endcase
		return v;
	endfunction

	function automatic acl_item_t add_item(logic [ZONE_W-1:0] zone, logic [ADDR_W-1:0] addr,
		logic [PLEN_W-1:0] plen, logic allow);
		acl_item_t it;
		it = '{CMD_ADD, zone, addr, plen, allow, '0};
		return it;
	endfunction

	function automatic acl_item_t lookup_item(logic [ADDR_W-1:0] addr, logic [HITS_W-1:0] hits);
		acl_item_t it;
		it = '{CMD_LOOKUP, '0, addr, '0, 1'b0, hits};
		return it;
	endfunction

	function automatic acl_item_t bare_item(logic [CMD_W-1:0] cmd);
		acl_item_t it;
		it = '{cmd, '0, '0, '0, 1'b0, '0};
		return it;
	endfunction

	function automatic acl_item_t random_rule();
		logic [PLEN_W-1:0] plen;
		case ($urandom_range(0, 9))
			0: plen = '0;
			1: plen = PLEN_W'($urandom_range(33, 63));
			2: plen = PLEN_W'(32);
			default: plen = PLEN_W'($urandom_range(1, 31));
		endcase
		return add_item(ZONE_W'($urandom_range(0, 7)), $urandom, plen,
			1'($urandom_range(0, 1)));
	endfunction

	// lookup mostly aimed at a stored rule: inside its prefix, or one bit off; else random
	function automatic acl_item_t random_lookup();
		int unsigned idx;
		int unsigned b;
		logic [ADDR_W-1:0] addr;
		logic [HITS_W-1:0] hits;
		if (shadow_count == 0 || $urandom_range(0, 4) == 0) begin
			addr = $urandom;
			hits = HITS_W'($urandom);
		end else begin
			idx = $urandom_range(0, shadow_count - 1);
			addr = (shadow_addr[idx] & shadow_mask[idx]) | ($urandom & ~shadow_mask[idx]);
			if ($urandom_range(0, 3) == 0) begin
				b = $urandom_range(0, 31);
				addr[b] = addr[b] ^ shadow_mask[idx][b];
			end
			case ($urandom_range(0, 3))
				0: hits = 8'hFF;
				1: hits = 8'h1 << shadow_zone[idx];
				default: hits = HITS_W'($urandom);
			endcase
		end
		return lookup_item(addr, hits);
	endfunction

	function automatic acl_item_t noise_item();
		acl_item_t it;
		it = '{CMD_W'($urandom_range(0, 3)), ZONE_W'($urandom), $urandom, PLEN_W'($urandom),
			1'($urandom), HITS_W'($urandom)};
		return it;
	endfunction

	// called and returns just after a rising edge
	task automatic send_item(acl_item_t it, bit may_idle = 1'b1);
		int unsigned gap;
		gap = 0;
		if (may_idle && !calm && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 14);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.command    <= it.command;
		req_ch.zone       <= it.zone;
		req_ch.address    <= it.address;
		req_ch.prefix_len <= it.prefix_len;
		req_ch.allow      <= it.allow;
		req_ch.zone_hits  <= it.zone_hits;
		do @(negedge clk); while (!req_ch.ready);
		@(posedge clk);
		verdict_q.push_back(acl_verdict(it));
		items_sent++;
	endtask

	// sender pauses until every expected result is back
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_filter(logic en);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= en;
		@(posedge clk);
		filter_on = en;
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_field(string name, logic want, logic got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0b, actual %0b at cycle %0d",
					name, want, got, cycles);
		end
	endtask

	// result checker, outputs sampled on the falling edge
	initial begin
		acl_verdict_t want;
		forever begin
			@(negedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				if (verdict_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result at cycle %0d", cycles);
				end else begin
					want = verdict_q.pop_front();
					check_field("permitted", want.permitted, rsp_ch.permitted);
					check_field("matched", want.matched, rsp_ch.matched);
					check_field("status", want.status, rsp_ch.status);
				end
			end
		end
	end

	// receiver: random stall bursts, a long hold on request, none when calm
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (calm) begin
				rsp_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 9) == 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left = $urandom_range(1, 14) - 1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic test_empty_table();
		send_item(lookup_item('0, 8'hFF));
		send_item('{CMD_RSVD, 3'h7, 32'hFFFF_FFFF, 6'h3F, 1'b1, 8'hFF});
		send_item(lookup_item(32'hFFFF_FFFF, 8'hFF));
		send_item(bare_item(CMD_CLEAR));
	endtask

	task automatic test_first_match();
		send_item(add_item(3'd2, 32'hC0A8_0100, 6'd24, 1'b0));
		send_item(add_item(3'd2, 32'hC0A8_0000, 6'd16, 1'b1));
		send_item(add_item(3'd7, 32'hFFFF_FFFF, 6'd32, 1'b1));
		// length past 32 behaves as a host rule
		send_item(add_item(3'd5, 32'h0A00_0000, 6'd63, 1'b1));
		// zero length matches any address
		send_item(add_item(3'd3, 32'h0000_0000, 6'd0, 1'b0));
		send_item(lookup_item(32'hC0A8_0105, 8'h04));
		send_item(lookup_item(32'hC0A8_0205, 8'h04));
		send_item(lookup_item(32'hFFFF_FFFF, 8'h80));
		send_item(lookup_item(32'hFFFF_FFFE, 8'h80));
		send_item(lookup_item(32'h0A00_0000, 8'h20));
		send_item(lookup_item(32'h0A00_0001, 8'h20));
		send_item(lookup_item(32'h1234_5678, 8'h08));
		send_item(lookup_item(32'hC0A8_0205, 8'h0C));
		send_item(lookup_item(32'hC0A8_0105, 8'h00));
	endtask

	task automatic test_filter_off();
		set_filter(1'b0);
		send_item(lookup_item(32'h1234_5678, 8'h08));
		send_item(add_item(3'd0, 32'h0000_0000, 6'd0, 1'b0));
		send_item(lookup_item(32'h0000_0000, 8'hFF));
		set_filter(1'b1);
		send_item(lookup_item(32'h0000_0000, 8'h01));
	endtask

	task automatic test_table_overflow();
		send_item(bare_item(CMD_CLEAR));
		for (int i = 0; i < RULE_DEPTH + 3; i++)
			send_item(random_rule());
		for (int i = 0; i < 12; i++)
			send_item(random_lookup());
	endtask

	// output held off long enough that the input must stall
	task automatic test_backpressure();
		drain();
		hold_left = 300;
		for (int i = 0; i < 16; i++)
			send_item(random_lookup(), 1'b0);
		drain();
	endtask

	task automatic run_random_round();
		int unsigned n_rules;
		int unsigned n_look;
		if ($urandom_range(0, 3) == 0)
			set_filter(1'b0);
		else if (!filter_on || $urandom_range(0, 5) == 0)
			set_filter(1'b1);
		if ($urandom_range(0, 4) != 0)
			send_item(bare_item(CMD_CLEAR));
		n_rules = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
		for (int i = 0; i < n_rules; i++)
			send_item(($urandom_range(0, 9) == 0) ? noise_item() : random_rule());
		n_look = $urandom_range(10, 25);
		for (int i = 0; i < n_look; i++)
			send_item(($urandom_range(0, 9) == 0) ? noise_item() : random_lookup());
	endtask

	task automatic test_random();
		while (items_sent < RANDOM_ITEMS)
			run_random_round();
	endtask

	task automatic test_calm();
		drain();
		calm = 1'b1;
		for (int i = 0; i < CALM_ITEMS; i++)
			send_item(($urandom_range(0, 2) == 0) ? random_rule() : random_lookup());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_CLEAR;
		req_ch.zone = '0;
		req_ch.address = '0;
		req_ch.prefix_len = '0;
		req_ch.allow = 1'b0;
		req_ch.zone_hits = '0;
		shadow_count = 0;
		filter_on = 1'b1;
		mismatches = 0;
		items_sent = 0;
		hold_left = 0;
		calm = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_empty_table();
		test_first_match();
		test_filter_off();
		test_table_overflow();
		test_backpressure();
		test_random();
		test_calm();
		drain();
		repeat (20) @(posedge clk);

		if (mismatches == 0 && verdict_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
